/* hw/rtl/assert_macros.svh */
// Assertion macros used by the top level of the hash table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition never holds at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* hw/rtl/lht_pkg.sv */
// Package with the shared widths, codes and state type of the hash table.
`default_nettype none

package lht_pkg;

   localparam int KEY_W       = 16;
   localparam int VAL_W       = 16;
   localparam int SLOT_W      = 6;
   localparam int KIND_W      = 2;
   localparam int STATUS_W    = 2;
   localparam int WORD_W      = 1 + KEY_W + VAL_W;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 24;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_INSERT    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOOKUP    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ_SLOT = 2'd2;

   // Response status codes.
   localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_HIT      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_MISS     = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_PROBE,
      ST_SLOT
   } state_type;

endpackage

`default_nettype wire

/* hw/rtl/lht_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module lht_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

/* hw/rtl/lht_hash.sv */
// Two-stage home slot unit: key modulo the table size by reciprocal multiply.
`default_nettype none

module lht_hash #(
   parameter int TABLE_SIZE = 64
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [lht_pkg::KEY_W-1:0]     key,
   output logic                               done,
   output logic [$clog2(TABLE_SIZE)-1:0]      home
);

   import lht_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int R_W   = IDX_W + 1;
   localparam logic [32:0] TWO32 = 33'h1_0000_0000;
   localparam logic [31:0] RECIP = 32'(TWO32 / TABLE_SIZE);

   logic [47:0]      prod;
   logic [31:0]      qt;
   logic [31:0]      diff;
   logic [R_W-1:0]   r_adj;

   logic             v1_ff, v1_in;
   logic             v2_ff, v2_in;
   logic [KEY_W-1:0] key1_ff, key1_in;
   logic [KEY_W-1:0] q1_ff, q1_in;
   logic [R_W-1:0]   r2_ff, r2_in;

   // The quotient estimate is never above the true quotient and at most one
   // below it, so the remainder stays under twice the table size.
   always_comb begin
      prod    = 48'(key) * 48'(RECIP);
      q1_in   = prod[47:32];
      key1_in = key;
      v1_in   = start;
      qt      = 32'(q1_ff) * 32'(TABLE_SIZE);
      diff    = 32'(key1_ff) - qt;
      r2_in   = R_W'(diff);
      v2_in   = v1_ff;
      r_adj   = (r2_ff >= R_W'(TABLE_SIZE)) ? r2_ff - R_W'(TABLE_SIZE) : r2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      key1_ff <= key1_in;
      q1_ff   <= q1_in;
      r2_ff   <= r2_in;
   end

   assign done = v2_ff;
   assign home = IDX_W'(r_adj);

endmodule

`default_nettype wire

/* hw/rtl/linear_probe_hash_table.sv */
// Top level of the linear probing hash table with its probe sequencer.
// Insert and lookup: the home slot is computed, then 1 to TABLE_SIZE slots are probed;
// the result register loads once it has room, and the next request is taken only after
// that, so requests never overlap. Probing reads one slot per cycle from the table RAM.
// Read-slot requests read their slot directly and load the result register likewise.
// After reset a clearing pass zeroes every slot before requests are taken.
`default_nettype none

`include "assert_macros.svh"

module linear_probe_hash_table #(
   parameter int TABLE_SIZE = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request channel.
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // [15:0] key, [31:16] value, [37:32] slot, [39:38] zero
   input  wire logic [lht_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // [1:0] kind
   input  wire logic [lht_pkg::KIND_W-1:0]        req_tuser,
   // Response channel.
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // [5:0] slot_index, [21:6] handler, [23:22] zero
   output logic      [lht_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // [1:0] status
   output logic      [lht_pkg::STATUS_W-1:0]      rsp_tuser
);

   import lht_pkg::*;

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

   // Unpacked request fields.
   logic [KEY_W-1:0]  req_key;
   logic [VAL_W-1:0]  req_value;
   logic [SLOT_W-1:0] req_slot;
   logic              slot_in_range;

   assign req_key   = req_tdata[15:0];
   assign req_value = req_tdata[31:16];
   assign req_slot  = req_tdata[37:32];
   assign slot_in_range = {7'd0, req_slot} < 13'(TABLE_SIZE);

   // Table RAM: each word holds the valid mark, the key and the handler.
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   logic [WORD_W-1:0]  wr_data;
   logic [IDX_W-1:0]   rd_addr;
   logic [WORD_W-1:0]  rd_data;
   logic               rd_valid;
   logic [KEY_W-1:0]   rd_key;
   logic [VAL_W-1:0]   rd_value;

   assign rd_valid = rd_data[WORD_W-1];
   assign rd_key   = rd_data[KEY_W+VAL_W-1:VAL_W];
   assign rd_value = rd_data[VAL_W-1:0];

   lht_ram #(
      .WIDTH(WORD_W),
      .DEPTH(TABLE_SIZE)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Home slot computation.
   logic             hash_start;
   logic             hash_done;
   logic [IDX_W-1:0] hash_home;

   lht_hash #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_hash (
      .clock(clock),
      .reset(reset),
      .start(hash_start),
      .key  (req_key),
      .done (hash_done),
      .home (hash_home)
   );

   // Sequencer state and held request fields.
   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [VAL_W-1:0]  value_ff, value_in;
   logic              miss_ff, miss_in;

   // Result register.
   logic                rsp_tvalid_ff, rsp_tvalid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [VAL_W-1:0]    rsp_handler_ff, rsp_handler_in;

   logic             out_free;
   logic             emit;
   logic             found;
   logic [IDX_W-1:0] nxt;

   // The result register can take a new result when it is empty or when its
   // current result transfers in this cycle.
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign nxt      = (cur_ff == LAST_IDX) ? '0 : cur_ff + 1'b1;

   always_comb begin
      state_in       = state_ff;
      cnt_in         = cnt_ff;
      cur_in         = cur_ff;
      kind_in        = kind_ff;
      key_in         = key_ff;
      value_in       = value_ff;
      miss_in        = miss_ff;
      rsp_tvalid_in  = rsp_tvalid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_handler_in = rsp_handler_ff;
      req_tready     = 1'b0;
      hash_start     = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = cur_ff;
      wr_data        = {1'b1, key_ff, value_ff};
      rd_addr        = cur_ff;
      emit           = 1'b0;
      found          = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep every slot once, writing a cleared valid mark.
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = '0;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == LAST_IDX) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            req_tready = 1'b1;
            rd_addr    = IDX_W'(req_slot);
            if (req_tvalid) begin
               kind_in  = req_tuser;
               key_in   = req_key;
               value_in = req_value;
               cur_in   = IDX_W'(req_slot);
               if (req_tuser == KIND_INSERT || req_tuser == KIND_LOOKUP) begin
                  hash_start = 1'b1;
                  state_in   = ST_HASH;
               end else begin
                  // Read-slot requests go straight to the RAM; an unused kind or
                  // a slot beyond the table answers as a miss.
                  miss_in  = !(req_tuser == KIND_READ_SLOT && slot_in_range);
                  state_in = ST_SLOT;
               end
            end
         end

         ST_HASH: begin
            if (hash_done) begin
               rd_addr  = hash_home;
               cur_in   = hash_home;
               cnt_in   = '0;
               state_in = ST_PROBE;
            end
         end

         ST_PROBE: begin
            // The RAM output holds the slot at cur_ff. The next slot is read
            // ahead so that one slot is examined per cycle.
            if (kind_ff == KIND_INSERT) begin
               found = !rd_valid;
            end else begin
               found = rd_valid && (rd_key == key_ff);
            end
            if (found || cnt_ff == LAST_IDX) begin
               // Hold the read address so the RAM output stays put on a stall.
               rd_addr = cur_ff;
               if (out_free) begin
                  emit     = 1'b1;
                  state_in = ST_IDLE;
                  if (found && kind_ff == KIND_INSERT) begin
                     wr_en          = 1'b1;
                     rsp_status_in  = STATUS_INSERTED;
                     rsp_slot_in    = SLOT_W'(cur_ff);
                     rsp_handler_in = '0;
                  end else if (found) begin
                     rsp_status_in  = STATUS_HIT;
                     rsp_slot_in    = SLOT_W'(cur_ff);
                     rsp_handler_in = rd_value;
                  end else begin
                     rsp_status_in  = (kind_ff == KIND_INSERT) ? STATUS_FULL : STATUS_MISS;
                     rsp_slot_in    = '0;
                     rsp_handler_in = '0;
                  end
               end
            end else begin
               rd_addr = nxt;
               cur_in  = nxt;
               cnt_in  = cnt_ff + 1'b1;
            end
         end

         ST_SLOT: begin
            rd_addr = cur_ff;
            if (out_free) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
               if (!miss_ff && rd_valid) begin
                  rsp_status_in  = STATUS_HIT;
                  rsp_slot_in    = SLOT_W'(cur_ff);
                  rsp_handler_in = rd_value;
               end else begin
                  rsp_status_in  = STATUS_MISS;
                  rsp_slot_in    = '0;
                  rsp_handler_in = '0;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         rsp_tvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cnt_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      kind_ff        <= kind_in;
      key_ff         <= key_in;
      value_ff       <= value_in;
      miss_ff        <= miss_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_handler_ff <= rsp_handler_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {2'b00, rsp_handler_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_status_ff;

   // The table is written only by the clearing pass or by a completing insert.
   `ASSERT_PROP(a_write_source, clock, reset,
      wr_en |-> (state_ff == ST_CLEAR) || (state_ff == ST_PROBE && kind_ff == KIND_INSERT),
      "table write outside clearing pass or insert")

   // A result is produced only when the result register has room for it.
   `ASSERT_PROP(a_emit_room, clock, reset,
      emit |-> out_free && (state_ff == ST_PROBE || state_ff == ST_SLOT),
      "result produced without room in the result register")

   // The hash unit finishes only while the sequencer waits for it.
   `ASSERT_PROP(a_hash_wait, clock, reset,
      hash_done |-> state_ff == ST_HASH,
      "home slot ready outside the hash wait")

   // A completing insert always reports the slot it wrote.
   `ASSERT_PROP(a_insert_report, clock, reset,
      wr_en && state_ff == ST_PROBE |=> rsp_tvalid_ff && rsp_status_ff == STATUS_INSERTED,
      "insert write without an inserted result")

endmodule

`default_nettype wire

/* test/linear_probe_hash_table_tb.sv */
// Self-checking testbench for the linear probing hash table, driven over its stream ports.
`default_nettype none

module linear_probe_hash_table_tb;
   import lht_pkg::*;

   localparam int TABLE_SIZE = 64;
   // The request kind that the block does not define; it must answer as a miss.
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int RANDOM_REQUESTS = 1600;
   // The limit covers the slowest legal run, with full probes, long stalls and long gaps.
   localparam int CYCLE_LIMIT = 1_200_000;
   localparam int LONG_HOLD_CYCLES = 300;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot_index;
      logic [VAL_W-1:0]    handler;
   } reply_type;

   // Mirror of the slot table. It predicts the reply to every accepted request and keeps
   // the predicted replies in order until the block delivers them.
   class slot_table_mirror_type;
      bit               occupied[TABLE_SIZE];
      logic [KEY_W-1:0] stored_key[TABLE_SIZE];
      logic [VAL_W-1:0] stored_handler[TABLE_SIZE];
      reply_type        pending_replies[$];
      int               failures = 0;

      function void note_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                 logic [VAL_W-1:0] value, logic [SLOT_W-1:0] slot);
         reply_type   r;
         int unsigned h;
         r = '{status: STATUS_MISS, slot_index: '0, handler: '0};
         h = key % TABLE_SIZE;
         case (kind)
            KIND_INSERT: begin
               // First free slot in probe order; duplicates are not detected.
               r.status = STATUS_FULL;
               for (int n = 0; n < TABLE_SIZE; n++) begin
                  if (!occupied[h]) begin
                     occupied[h]       = 1'b1;
                     stored_key[h]     = key;
                     stored_handler[h] = value;
                     r.status          = STATUS_INSERTED;
                     r.slot_index      = h[SLOT_W-1:0];
                     break;
                  end
                  h = (h + 1) % TABLE_SIZE;
               end
            end
            KIND_LOOKUP: begin
               for (int n = 0; n < TABLE_SIZE; n++) begin
                  if (occupied[h] && stored_key[h] == key) begin
                     r.status     = STATUS_HIT;
                     r.slot_index = h[SLOT_W-1:0];
                     r.handler    = stored_handler[h];
                     break;
                  end
                  h = (h + 1) % TABLE_SIZE;
               end
            end
            KIND_READ_SLOT: begin
               if (slot < TABLE_SIZE && occupied[slot]) begin
                  r.status     = STATUS_HIT;
                  r.slot_index = slot;
                  r.handler    = stored_handler[slot];
               end
            end
            default: ;
         endcase
         pending_replies.push_back(r);
      endfunction

      function void check_reply(logic [STATUS_W-1:0] status, logic [SLOT_W-1:0] slot_index,
                                logic [VAL_W-1:0] handler);
         reply_type want;
         if (pending_replies.size() == 0) begin
            $error("reply with no request outstanding: status %0d slot_index %0d handler %0h",
                   status, slot_index, handler);
            failures++;
            return;
         end
         want = pending_replies.pop_front();
         if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            failures++;
         end
         if (slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, slot_index);
            failures++;
         end
         if (handler !== want.handler) begin
            $error("handler: expected %0h, got %0h", want.handler, handler);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Request side, driven by the stimulus process below.
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_TDATA_W-1:0]   req_tdata = '0;   // [15:0] key, [31:16] value, [37:32] slot
   logic [KIND_W-1:0]        req_tuser = '0;   // [1:0] kind

   // Reply side, drained by the receiver process below.
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]   rsp_tdata;        // [5:0] slot_index, [21:6] handler
   logic [STATUS_W-1:0]      rsp_tuser;        // [1:0] status

   // Set by the stimulus side: quiet_phase turns off idling on both sides, and
   // long_hold_req asks the receiver for its one long stall.
   logic                     quiet_phase   = 1'b0;
   logic                     long_hold_req = 1'b0;
   logic                     long_hold_done = 1'b0;
   int                       hold_left = 0;
   int                       cycle_count = 0;

   slot_table_mirror_type mirror = new();

   linear_probe_hash_table #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop in case the block hangs or loses a reply.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Mostly back-to-back, often a few cycles idle, now and then a long pause.
   function automatic int pick_gap(logic quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Half of the keys land on a few crowded home slots, including the two at the top
   // of the table, so that probe chains grow long and wrap back to slot 0.
   function automatic logic [KEY_W-1:0] random_key();
      logic [5:0] homes[5];
      logic [5:0] home;
      homes = '{6'd0, 6'd1, 6'd31, 6'd62, 6'd63};
      if ($urandom_range(0, 1) == 0) begin
         home = homes[$urandom_range(0, 4)];
         return {10'($urandom_range(0, 1023)), home};
      end
      return KEY_W'($urandom_range(0, 65535));
   endfunction

   // Receiver: checks every reply transfer and paces rsp_tready. The hold counter
   // stalls the reply side; the one long hold lets the block back up into its input.
   always @(posedge clock) begin
      int gap;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            mirror.check_reply(rsp_tuser, rsp_tdata[SLOT_W-1:0],
                               rsp_tdata[SLOT_W+VAL_W-1:SLOT_W]);
         if (long_hold_req && !long_hold_done) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD_CYCLES;
            rsp_tready     <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= (hold_left == 1);
         end else if (rsp_tvalid && rsp_tready) begin
            gap = pick_gap(quiet_phase);
            hold_left  <= gap;
            rsp_tready <= (gap == 0);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Offers one request, waits for its transfer, records it in the mirror and then
   // idles for a random gap. Valid stays high when no gap follows.
   task automatic send_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                               logic [VAL_W-1:0] value, logic [SLOT_W-1:0] slot);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {2'b00, slot, value, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      mirror.note_request(kind, key, value, slot);
      gap = pick_gap(quiet_phase);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      logic [KEY_W-1:0] known_keys[$];
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
      int               pick;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. The first inserts build a chain from slot 0 through slot 3 that
      // wraps from slot 63: keys 0 and 0x40 share home slot 0, keys 0xFFFF and 0x3F
      // share home slot 63, and 0xFFFF goes in twice.
      send_request(KIND_INSERT, 16'h0000, 16'h0000, 6'd0);   // handler value zero
      send_request(KIND_INSERT, 16'hFFFF, 16'hFFFF, 6'd63);
      send_request(KIND_INSERT, 16'h0040, 16'h1234, 6'd0);
      send_request(KIND_INSERT, 16'h003F, 16'hA5A5, 6'd0);   // wraps to slot 2
      send_request(KIND_INSERT, 16'hFFFF, 16'h5A5A, 6'd0);   // duplicate key, slot 3
      send_request(KIND_LOOKUP, 16'h0000, 16'hFFFF, 6'd0);
      send_request(KIND_LOOKUP, 16'hFFFF, 16'h0000, 6'd0);   // first copy wins
      send_request(KIND_LOOKUP, 16'h003F, 16'h0000, 6'd0);
      send_request(KIND_LOOKUP, 16'h0040, 16'h0000, 6'd0);
      send_request(KIND_LOOKUP, 16'h1234, 16'h0000, 6'd0);   // full scan, then a miss
      send_request(KIND_READ_SLOT, 16'h0000, 16'h0000, 6'd0);
      send_request(KIND_READ_SLOT, 16'hFFFF, 16'hFFFF, 6'd63);
      send_request(KIND_READ_SLOT, 16'h0000, 16'h0000, 6'd3);
      send_request(KIND_READ_SLOT, 16'h0000, 16'h0000, 6'd40); // empty slot
      send_request(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 6'd63);
      send_request(KIND_UNUSED, 16'h0000, 16'h0000, 6'd0);
      known_keys = {16'h0000, 16'hFFFF, 16'h0040, 16'h003F};

      // Random part. Inserts are rare enough that the table fills about halfway
      // through, so lookups run over both a sparse and a full table and the late
      // inserts are dropped as full. Two stretches run without any idling.
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         quiet_phase <= (i >= 300 && i < 450) || (i >= 1100 && i < 1250);
         if (i == 24) long_hold_req <= 1'b1;
         pick  = $urandom_range(0, 99);
         value = ($urandom_range(0, 9) == 0) ? {VAL_W{pick[0]}}
                                             : VAL_W'($urandom_range(0, 65535));
         if (pick < 8) begin
            key = random_key();
            known_keys.push_back(key);
            send_request(KIND_INSERT, key, value, SLOT_W'($urandom_range(0, 63)));
         end else if (pick < 63) begin
            key = ($urandom_range(0, 99) < 65)
                  ? known_keys[$urandom_range(0, known_keys.size() - 1)] : random_key();
            send_request(KIND_LOOKUP, key, value, SLOT_W'($urandom_range(0, 63)));
         end else if (pick < 95) begin
            send_request(KIND_READ_SLOT, random_key(), value,
                         SLOT_W'($urandom_range(0, 63)));
         end else begin
            send_request(KIND_UNUSED, random_key(), value, SLOT_W'($urandom_range(0, 63)));
         end
      end
      req_tvalid <= 1'b0;

      // Drain: every reply must come back, then allow a full probe's worth of cycles
      // for anything unexpected to show up.
      while (mirror.pending_replies.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mirror.failures == 0 && mirror.pending_replies.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
+incdir+hw/rtl
hw/rtl/lht_pkg.sv
hw/rtl/lht_ram.sv
hw/rtl/lht_hash.sv
hw/rtl/linear_probe_hash_table.sv
test/linear_probe_hash_table_tb.sv
